@@ hw/rtl/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants of the fragment reassembly table
// Status codes, operation codes, register indexes and the cell command type.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned RECV_W = 13;
  localparam logic [RECV_W-1:0] RECV_MAX = 13'd8191;
  localparam logic [5:0] WAIT_NOTFOUND = 6'd40;
  localparam logic [5:0] WAIT_ACCEPT = 6'd20;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_FRAG = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NOTFOUND = 3'd0,
    ST_DUP = 3'd1,
    ST_PARTIAL = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_CORRUPT = 3'd4,
    ST_ADDED = 3'd5,
    ST_FULL = 3'd6,
    ST_REMOVED = 3'd7
  } status_t;

  typedef enum logic {
    REG_MISSION_MODE = 1'b0,
    REG_MAX_BYTES = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_OUT
  } state_t;

  // per-cell command broadcast from the controller
  typedef struct packed {
    logic        add;     // drop by source then append
    logic        remove;  // drop by message id
    logic        frag;    // apply fragment
    logic        mmode;
    logic [15:0] msg;
    logic [15:0] mis;
    logic [7:0]  src;
    logic [11:0] tot;
    logic        cor;
    logic        misf;
    logic [7:0]  pay;
  } cmd_t;

endpackage

@@ hw/rtl/frt_if.sv @@
// ----------------------------------------------------------------------------
// frt_if: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface frt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] message_id;
  logic [15:0] mission_id;
  logic [7:0]  source_node;
  logic [11:0] total_bytes;
  logic        corrupted_flag;
  logic        mission_flag;
  logic [3:0]  fragment_index;
  logic [7:0]  payload_bytes;
  modport source (output valid, operation, message_id, mission_id, source_node,
                  total_bytes, corrupted_flag, mission_flag, fragment_index,
                  payload_bytes, input ready);
  modport sink (input valid, operation, message_id, mission_id, source_node,
                total_bytes, corrupted_flag, mission_flag, fragment_index,
                payload_bytes, output ready);
endinterface

interface frt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  remaining_bytes;
  logic [5:0]  wait_base;
  logic        is_mission;
  logic [15:0] done_message_id;
  logic [7:0]  done_source_node;
  modport source (output valid, status, remaining_bytes, wait_base, is_mission,
                  done_message_id, done_source_node, input ready);
  modport sink (input valid, status, remaining_bytes, wait_base, is_mission,
                done_message_id, done_source_node, output ready);
endinterface

interface frt_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/frt_cell.sv @@
// ----------------------------------------------------------------------------
// frt_cell: one table entry
// Holds one entry; compacts by taking its upstream neighbor's entry.
// ----------------------------------------------------------------------------
module frt_cell #(
  parameter int unsigned MAX_FRAGMENTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,       // command strobe
  input  frt_pkg::cmd_t            cmd,
  input  logic                     take_next,  // load entry from next cell
  input  logic                     append,     // write new entry here
  input  logic                     frag_sel,   // this cell takes the fragment
  input  logic [3:0]               frag_idx,
  // entry handed to the previous cell
  output logic                     valid_o,
  output logic                     drop_o,     // dropped by current command
  output logic                     fmatch_o,   // fragment key matches
  output logic [15:0]              msg_o,
  output logic [15:0]              mis_o,
  output logic [7:0]               src_o,
  output logic [11:0]              size_o,
  output logic [frt_pkg::RECV_W-1:0] recv_o,
  output logic [1:0]               flags_o,
  output logic [MAX_FRAGMENTS-1:0] map_o,
  // entry from the next cell
  input  logic                     valid_i,
  input  logic [15:0]              msg_i,
  input  logic [15:0]              mis_i,
  input  logic [7:0]               src_i,
  input  logic [11:0]              size_i,
  input  logic [frt_pkg::RECV_W-1:0] recv_i,
  input  logic [1:0]               flags_i,
  input  logic [MAX_FRAGMENTS-1:0] map_i
);
  logic                       valid_r;
  logic [15:0]                msg_r, mis_r;
  logic [7:0]                 src_r;
  logic [11:0]                size_r;
  logic [frt_pkg::RECV_W-1:0] recv_r;
  logic [1:0]                 flags_r;
  logic [MAX_FRAGMENTS-1:0]   map_r;
  logic [frt_pkg::RECV_W:0]   sum;
  logic [MAX_FRAGMENTS-1:0]   bit_m;

  assign valid_o = valid_r;
  assign msg_o = msg_r;
  assign mis_o = mis_r;
  assign src_o = src_r;
  assign size_o = size_r;
  assign recv_o = recv_r;
  assign flags_o = flags_r;
  assign map_o = map_r;
  assign drop_o = valid_r && ((cmd.add && src_r == cmd.src) ||
                              (cmd.remove && msg_r == cmd.msg));
  assign fmatch_o = valid_r && (cmd.mmode ? (mis_r == cmd.mis) : (msg_r == cmd.msg));
  assign sum = {1'b0, recv_r} + {{(frt_pkg::RECV_W-7){1'b0}}, cmd.pay};
  assign bit_m = MAX_FRAGMENTS'(1) << frag_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      if (append) begin
        valid_r <= 1'b1;
      end else if (take_next) begin
        valid_r <= valid_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (append) begin
        msg_r <= cmd.msg;
        mis_r <= cmd.mis;
        src_r <= cmd.src;
        size_r <= cmd.tot;
        recv_r <= '0;
        flags_r <= {cmd.misf, cmd.cor};
        map_r <= '0;
      end else if (take_next) begin
        msg_r <= msg_i;
        mis_r <= mis_i;
        src_r <= src_i;
        size_r <= size_i;
        recv_r <= recv_i;
        flags_r <= flags_i;
        map_r <= map_i;
      end else if (frag_sel) begin
        recv_r <= sum[frt_pkg::RECV_W] ? frt_pkg::RECV_MAX : sum[frt_pkg::RECV_W-1:0];
        map_r <= map_r | bit_m;
      end
    end
  end
endmodule

@@ hw/rtl/fragment_reassembly_table.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembly_table: ordered table of packets under reassembly
// Row of entry cells; drops compact the row one slot per pass.
// ----------------------------------------------------------------------------
//  channel | dir | transfer when        | payload
//  in_     | in  | in_valid & in_ready  | operation, ids, source, sizes, flags
//  out_    | out | out_valid & out_ready| status, remaining, wait, done fields
//  cfg_    | in  | cfg_valid & cfg_ready| register index, write data
//
// Add and remove: one compaction pass per work cycle; each pass removes the
// oldest dropped entry by shifting later cells down one place; finished when
// no valid cell matches, and then an add appends in that same cycle.
// Fragments: match and update in the same work cycle. Result is valid the
// cycle after the last work cycle; the next input transfer waits until the
// result transfer is done.
// Reset clears cell valid bits, registers and control; entries need none.
module fragment_reassembly_table #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned MAX_FRAGMENTS = 16
) (
  input logic     clk,
  input logic     rst_n,
  frt_in_if.sink  in_ch,
  frt_out_if.source out_ch,
  frt_cfg_if.sink cfg_ch
);
  localparam int unsigned N = TABLE_ENTRIES;
  localparam int unsigned RW = frt_pkg::RECV_W;

  frt_pkg::state_t state_r, state_nxt;
  frt_pkg::cmd_t   cmd_r;
  logic [3:0]      frag_r;
  logic            mmode_r;
  logic [7:0]      maxb_r;

  // cell wiring, index N is a constant empty cell
  logic [N:0]             v_w;
  logic [N-1:0]           drop_w, fm_w;
  logic [15:0]            msg_w [N+1];
  logic [15:0]            mis_w [N+1];
  logic [7:0]             src_w [N+1];
  logic [11:0]            size_w [N+1];
  logic [RW-1:0]          recv_w [N+1];
  logic [1:0]             flg_w [N+1];
  logic [MAX_FRAGMENTS-1:0] map_w [N+1];

  logic [N-1:0] take_w, app_w, sel_w, first_fm;
  logic         any_drop, any_fm, step;

  // matched entry
  logic [15:0] m_msg;
  logic [7:0]  m_src;
  logic [11:0] m_size;
  logic [RW-1:0] m_recv;
  logic [1:0]  m_flg;
  logic [MAX_FRAGMENTS-1:0] m_map;
  logic        frag_dup;
  logic [RW:0] m_sum;
  logic [RW-1:0] m_rec;
  logic [RW-1:0] m_left;

  // output register
  logic        ovalid_r;
  logic [2:0]  ost_r;
  logic [7:0]  orem_r;
  logic [5:0]  owait_r;
  logic        omis_r;
  logic [15:0] omsg_r;
  logic [7:0]  osrc_r;

  logic out_fire;
  logic finish;

  assign v_w[N] = 1'b0;
  assign msg_w[N] = '0;
  assign mis_w[N] = '0;
  assign src_w[N] = '0;
  assign size_w[N] = '0;
  assign recv_w[N] = '0;
  assign flg_w[N] = '0;
  assign map_w[N] = '0;

  assign any_drop = |drop_w;
  assign any_fm = |fm_w;

  // oldest matching cell, and everything at or after the first drop shifts
  always_comb begin
    logic seen_d, seen_f;
    seen_d = 1'b0;
    seen_f = 1'b0;
    for (int i = 0; i < N; i++) begin
      first_fm[i] = fm_w[i] && !seen_f;
      take_w[i] = seen_d || drop_w[i];
      seen_d = seen_d || drop_w[i];
      seen_f = seen_f || fm_w[i];
      app_w[i] = 1'b0;
      sel_w[i] = 1'b0;
    end
    if (state_r == frt_pkg::S_WORK) begin
      if (!any_drop && cmd_r.add) begin
        for (int i = 0; i < N; i++) begin
          app_w[i] = !v_w[i] && (i == 0 || v_w[i-1 < 0 ? 0 : i-1]);
        end
      end
      if (cmd_r.frag) begin
        sel_w = first_fm;
      end
    end
  end

  assign step = (state_r == frt_pkg::S_WORK);

  for (genvar g = 0; g < N; g++) begin : g_cell
    frt_cell #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_cell (
      .clk(clk), .rst_n(rst_n), .step(step), .cmd(cmd_r),
      .take_next(take_w[g] && any_drop), .append(app_w[g]),
      .frag_sel(sel_w[g] && !frag_dup), .frag_idx(frag_r),
      .valid_o(v_w[g]), .drop_o(drop_w[g]), .fmatch_o(fm_w[g]),
      .msg_o(msg_w[g]), .mis_o(mis_w[g]), .src_o(src_w[g]), .size_o(size_w[g]),
      .recv_o(recv_w[g]), .flags_o(flg_w[g]), .map_o(map_w[g]),
      .valid_i(v_w[g+1]), .msg_i(msg_w[g+1]), .mis_i(mis_w[g+1]),
      .src_i(src_w[g+1]), .size_i(size_w[g+1]), .recv_i(recv_w[g+1]),
      .flags_i(flg_w[g+1]), .map_i(map_w[g+1])
    );
  end

  // matched entry, one-hot mux
  always_comb begin
    m_msg = '0; m_src = '0; m_size = '0; m_recv = '0; m_flg = '0; m_map = '0;
    for (int i = 0; i < N; i++) begin
      if (first_fm[i]) begin
        m_msg |= msg_w[i]; m_src |= src_w[i]; m_size |= size_w[i];
        m_recv |= recv_w[i]; m_flg |= flg_w[i]; m_map |= map_w[i];
      end
    end
    // index past the fragment map counts as already seen
    frag_dup = ({28'd0, frag_r} >= 32'(MAX_FRAGMENTS)) ||
               (|(m_map & (MAX_FRAGMENTS'(1) << frag_r)));
    m_sum = {1'b0, m_recv} + {{(RW-7){1'b0}}, cmd_r.pay};
    m_rec = m_sum[RW] ? frt_pkg::RECV_MAX : m_sum[RW-1:0];
    m_left = (m_rec >= {1'b0, m_size}) ? '0 : ({1'b0, m_size} - m_rec);
  end

  // control
  assign out_fire = ovalid_r && out_ch.ready;
  assign in_ch.ready = (state_r == frt_pkg::S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frt_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = frt_pkg::S_WORK;
      frt_pkg::S_WORK: if (!((cmd_r.add || cmd_r.remove) && any_drop))
                         state_nxt = frt_pkg::S_IDLE;
      default: state_nxt = frt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r.add <= in_ch.operation == frt_pkg::OP_ADD;
      cmd_r.remove <= in_ch.operation == frt_pkg::OP_REMOVE;
      cmd_r.frag <= in_ch.operation == frt_pkg::OP_FRAG;
      cmd_r.mmode <= mmode_r;
      cmd_r.msg <= in_ch.message_id;
      cmd_r.mis <= in_ch.mission_id;
      cmd_r.src <= in_ch.source_node;
      cmd_r.tot <= in_ch.total_bytes;
      cmd_r.cor <= in_ch.corrupted_flag;
      cmd_r.misf <= in_ch.mission_flag;
      cmd_r.pay <= in_ch.payload_bytes;
      frag_r <= in_ch.fragment_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmode_r <= 1'b0;
      maxb_r <= 8'd255;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        frt_pkg::REG_MISSION_MODE: mmode_r <= cfg_ch.data[0];
        frt_pkg::REG_MAX_BYTES:    maxb_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign finish = (state_r == frt_pkg::S_WORK) && (state_nxt == frt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (finish) begin
      ovalid_r <= 1'b1;
    end else if (out_fire) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      ost_r <= frt_pkg::ST_NOTFOUND;
      orem_r <= '0; owait_r <= '0; omis_r <= 1'b0; omsg_r <= '0; osrc_r <= '0;
      if (cmd_r.add) begin
        ost_r <= v_w[N-1] ? frt_pkg::ST_FULL : frt_pkg::ST_ADDED;
      end else if (cmd_r.remove) begin
        ost_r <= frt_pkg::ST_REMOVED;
      end else if (cmd_r.frag) begin
        if (!any_fm) begin
          orem_r <= maxb_r;
          owait_r <= frt_pkg::WAIT_NOTFOUND;
        end else if (frag_dup) begin
          ost_r <= frt_pkg::ST_DUP;
        end else begin
          orem_r <= (m_left > {5'd0, maxb_r}) ? maxb_r : m_left[7:0];
          owait_r <= frt_pkg::WAIT_ACCEPT;
          if (m_rec == {1'b0, m_size}) begin
            if (!m_flg[0]) begin
              ost_r <= frt_pkg::ST_COMPLETE;
              omis_r <= m_flg[1];
              omsg_r <= m_msg;
              osrc_r <= m_src;
            end else begin
              ost_r <= frt_pkg::ST_CORRUPT;
            end
          end else begin
            ost_r <= frt_pkg::ST_PARTIAL;
          end
        end
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ost_r;
  assign out_ch.remaining_bytes = orem_r;
  assign out_ch.wait_base = owait_r;
  assign out_ch.is_mission = omis_r;
  assign out_ch.done_message_id = omsg_r;
  assign out_ch.done_source_node = osrc_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != frt_pkg::S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_valid_front: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frt_pkg::S_IDLE) |-> ((v_w[N-1:0] & (v_w[N-1:0] + 1'b1)) == '0))
    else $error("valid entries not packed at front");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !ovalid_r) else $error("result overwritten");
`endif
endmodule
